/* hdl/tsc_pkg.sv */
// tsc_pkg: word types, register map and fixed constants of the star centroid block
// used by thresholded_star_centroid; depends on nothing else
package tsc_pkg;

  typedef struct packed {
    logic [15:0] pixel_value;
    logic [12:0] pixel_col;
    logic [12:0] pixel_row;
    logic        frame_end;
  } in_word_t;

  typedef struct packed {
    logic [20:0] centroid_col_q8;
    logic [20:0] centroid_row_q8;
    logic        no_mass;
  } out_word_t;

  // register indexes (byte address is four times the index)
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_BOX_X        = 3'd2;
  localparam logic [2:0] REG_BOX_Y        = 3'd3;
  localparam logic [2:0] REG_BOX_SIZE     = 3'd4;
  localparam logic [2:0] REG_THR_MODE     = 3'd5;

  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_BOX   = 2'd1;
  localparam logic [1:0] MODE_SMART = 2'd2;
  // unused code, behaves as no threshold
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam logic [27:0] BOXSUM_MAX = 28'hFFF_FFFF;
  localparam logic [11:0] COUNT_MAX  = 12'hFFF;
  localparam logic [20:0] OUT_MAX    = 21'h1F_FFFF;
  localparam logic [3:0]  CUT_DIV    = 4'd10;

  // x / 10 as (x * CUT_RECIP) >> CUT_SHIFT, exact for x below 2^26
  localparam logic [24:0] CUT_RECIP  = 25'd26843546;
  localparam int          CUT_SHIFT  = 28;

endpackage

/* hdl/tsc_ram.sv */
// tsc_ram: generic simple dual-port ram, one write and one registered read port
// used by thresholded_star_centroid for the box pixel store; no dependencies
module tsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hdl/thresholded_star_centroid.sv */
// Thresholded star centroid. Pixels are taken one per clock with their image
// position; box pixels go into a MAX_BOX x MAX_BOX ram and the box and
// background sums are kept in registers. After the word marked frame_end the
// input stalls while the block forms the threshold, sweeps the box out of the
// ram one pixel a clock and runs a shared bit-serial divider for the mean and
// the two offsets (one quotient bit a clock, NW bits,
// NW = max(3*log2(MAX_BOX)+32, 40), 50 at the default); the tenth of the gap
// up to the peak is a reciprocal multiply. A frame needs up to three divisions.
// The result sits in an output register, so pixels of the next frame are taken
// while it waits. Registers: image_width 0x00, image_height 0x04, box_x 0x08,
// box_y 0x0c, box_size 0x10, threshold_mode 0x14.
module thresholded_star_centroid #(
  parameter int MAX_BOX     = 64,
  parameter int FRAME_WIDTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tsc_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tsc_pkg::out_word_t out_word_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IW    = $clog2(MAX_BOX);
  localparam int SW    = $clog2(MAX_BOX + 1);
  localparam int DEPTH = MAX_BOX * MAX_BOX;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = 24;
  localparam int MW    = 2 * IW + WW;
  localparam int SXW   = 3 * IW + WW;
  localparam int PW    = IW + WW;
  localparam int TW    = 40;
  localparam int NW    = (SXW + 8 > 40) ? SXW + 8 : 40;
  localparam int DW    = MW;
  localparam int CW    = $clog2(NW + 1);
  localparam int OW    = IW + 8;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_THR, S_CUTP, S_CUT, S_SWEEP, S_DRAIN, S_OX, S_OY, S_PUT
  } state_e;

  state_e state_q;

  logic [13:0] image_width_q, image_height_q;
  logic [12:0] box_x_q, box_y_q;
  logic [6:0]  box_size_q;
  logic [1:0]  thr_mode_q;

  logic [31:0] frame_sum_q;
  logic [11:0] frame_count_q;
  logic [27:0] box_sum_q;
  logic [15:0] box_peak_q;

  logic [TW-1:0]  thr_q;
  logic [NW-1:0]  num_q;
  logic [DW-1:0]  den_q, rem_q;
  logic [CW-1:0]  cnt_q;
  logic [IW-1:0]  ci_q, cj_q, i2_q, j2_q;
  logic [IW-1:0]  i1_q, j1_q;
  logic           v1_q, v2_q;
  logic [WW-1:0]  w_q;
  logic [SXW-1:0] sx_q, sy_q;
  logic [MW-1:0]  mass_q;
  logic [OW-1:0]  ox_q, oy_q;
  logic           out_valid_q;
  tsc_pkg::out_word_t out_q;

  // box side, saturated to 1..MAX_BOX
  logic [8:0]    bsz9, side9;
  logic [SW-1:0] side;
  assign bsz9  = 9'(box_size_q);
  assign side9 = (box_size_q == 7'd0) ? 9'd1 : ((bsz9 > 9'(MAX_BOX)) ? 9'(MAX_BOX) : bsz9);
  assign side  = side9[SW-1:0];

  // pixel classification
  logic [15:0] col16, row16, bx16, by16, s16, fw16, col_off, row_off;
  logic        acc, in_img, in_box, in_frm, ram_we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0] pval;

  assign pval    = in_word_i.pixel_value;
  assign col16   = 16'(in_word_i.pixel_col);
  assign row16   = 16'(in_word_i.pixel_row);
  assign bx16    = 16'(box_x_q);
  assign by16    = 16'(box_y_q);
  assign s16     = 16'(side);
  assign fw16    = 16'(FRAME_WIDTH);
  assign col_off = col16 - bx16;
  assign row_off = row16 - by16;

  assign in_stall_o = (state_q != S_IDLE);
  assign acc        = in_valid_i && !in_stall_o;
  assign in_img     = (14'(in_word_i.pixel_col) < image_width_q) &&
                      (14'(in_word_i.pixel_row) < image_height_q);
  assign in_box     = (col16 >= bx16) && (col16 < bx16 + s16) &&
                      (row16 >= by16) && (row16 < by16 + s16);
  assign in_frm     = (col16 + fw16 >= bx16) && (col16 < bx16 + s16 + fw16) &&
                      (row16 + fw16 >= by16) && (row16 < by16 + s16 + fw16);
  assign ram_we     = acc && in_img && in_box;
  assign waddr      = AW'(row_off[IW-1:0]) * AW'(MAX_BOX) + AW'(col_off[IW-1:0]);
  assign raddr      = AW'(cj_q) * AW'(MAX_BOX) + AW'(ci_q);

  // the store is written only while idle and read only while sweeping,
  // so the two ports never meet on one entry
  logic [15:0] ram_rdata;
  tsc_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_box_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (pval),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // accumulator next values for an accepted pixel
  logic [28:0] bsum_add;
  logic [32:0] fsum_add;
  assign bsum_add = {1'b0, box_sum_q} + 29'(pval);
  assign fsum_add = {1'b0, frame_sum_q} + 33'(pval);

  // one restoring division step
  logic [DW:0]   rem_sh;
  logic          ge;
  logic [DW-1:0] rem_nx;
  logic [NW-1:0] num_nx;
  logic          div_last;
  assign rem_sh   = {rem_q, num_q[NW-1]};
  assign ge       = rem_sh >= {1'b0, den_q};
  assign rem_nx   = ge ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
  assign num_nx   = {num_q[NW-2:0], ge};
  assign div_last = (cnt_q == CW'(1));

  // gap to the peak is below 2^24, so the reciprocal is exact
  logic [48:0] cut_prod;
  assign cut_prod = 49'(num_q[23:0]) * 49'(tsc_pkg::CUT_RECIP);

  // sweep weight
  logic [TW-1:0] p40, peak40;
  logic [WW-1:0] w_d;
  logic [PW-1:0] xprod, yprod;
  logic [2*SW-1:0] ss;
  logic          last_i, last_j;
  assign p40    = TW'({ram_rdata, 8'h00});
  assign peak40 = TW'({box_peak_q, 8'h00});
  assign w_d    = (p40 > thr_q) ? WW'(p40 - thr_q) : '0;
  assign xprod  = PW'(i2_q) * PW'(w_q);
  assign yprod  = PW'(j2_q) * PW'(w_q);
  assign ss     = (2*SW)'(side) * (2*SW)'(side);
  assign last_i = (SW'(ci_q) == side - SW'(1));
  assign last_j = (SW'(cj_q) == side - SW'(1));

  logic [21:0] ocol, orow;
  logic        can_put;
  assign ocol    = {1'b0, box_x_q, 8'h00} + 22'(ox_q);
  assign orow    = {1'b0, box_y_q, 8'h00} + 22'(oy_q);
  assign can_put = !out_valid_q || !out_stall_i;

  // configuration port
  logic cfg_we;
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[4:2])
      tsc_pkg::REG_IMAGE_WIDTH:  prdata = 32'(image_width_q);
      tsc_pkg::REG_IMAGE_HEIGHT: prdata = 32'(image_height_q);
      tsc_pkg::REG_BOX_X:        prdata = 32'(box_x_q);
      tsc_pkg::REG_BOX_Y:        prdata = 32'(box_y_q);
      tsc_pkg::REG_BOX_SIZE:     prdata = 32'(box_size_q);
      tsc_pkg::REG_THR_MODE:     prdata = 32'(thr_mode_q);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= 14'd8192;
      image_height_q <= 14'd8192;
      box_x_q        <= '0;
      box_y_q        <= '0;
      box_size_q     <= 7'd16;
      thr_mode_q     <= tsc_pkg::MODE_SMART;
    end else if (cfg_we) begin
      case (paddr[4:2])
        tsc_pkg::REG_IMAGE_WIDTH:  image_width_q  <= pwdata[13:0];
        tsc_pkg::REG_IMAGE_HEIGHT: image_height_q <= pwdata[13:0];
        tsc_pkg::REG_BOX_X:        box_x_q        <= pwdata[12:0];
        tsc_pkg::REG_BOX_Y:        box_y_q        <= pwdata[12:0];
        tsc_pkg::REG_BOX_SIZE:     box_size_q     <= pwdata[6:0];
        tsc_pkg::REG_THR_MODE:     thr_mode_q     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      frame_sum_q   <= '0;
      frame_count_q <= '0;
      box_sum_q     <= '0;
      box_peak_q    <= '0;
      thr_q         <= '0;
      num_q         <= '0;
      den_q         <= '0;
      rem_q         <= '0;
      cnt_q         <= '0;
      ci_q          <= '0;
      cj_q          <= '0;
      i1_q          <= '0;
      j1_q          <= '0;
      i2_q          <= '0;
      j2_q          <= '0;
      v1_q          <= 1'b0;
      v2_q          <= 1'b0;
      w_q           <= '0;
      sx_q          <= '0;
      sy_q          <= '0;
      mass_q        <= '0;
      ox_q          <= '0;
      oy_q          <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      // sweep pipeline: ram read, weight, accumulate
      v1_q <= (state_q == S_SWEEP);
      i1_q <= ci_q;
      j1_q <= cj_q;
      v2_q <= v1_q;
      i2_q <= i1_q;
      j2_q <= j1_q;
      w_q  <= w_d;
      if (v2_q) begin
        sx_q   <= sx_q + SXW'(xprod);
        sy_q   <= sy_q + SXW'(yprod);
        mass_q <= mass_q + MW'(w_q);
      end

      if (state_q == S_THR || state_q == S_OX || state_q == S_OY) begin
        num_q <= num_nx;
        rem_q <= rem_nx;
        cnt_q <= cnt_q - CW'(1);
      end

      case (state_q)
        S_IDLE: begin
          if (acc) begin
            if (in_img && in_box) begin
              box_sum_q <= bsum_add[28] ? tsc_pkg::BOXSUM_MAX : bsum_add[27:0];
              if (pval > box_peak_q) begin
                box_peak_q <= pval;
              end
            end else if (in_img && in_frm) begin
              frame_sum_q <= fsum_add[32] ? 32'hFFFF_FFFF : fsum_add[31:0];
              if (frame_count_q != tsc_pkg::COUNT_MAX) begin
                frame_count_q <= frame_count_q + 12'd1;
              end
            end
            if (in_word_i.frame_end) begin
              state_q <= S_PREP;
            end
          end
        end
        S_PREP: begin
          thr_q <= '0;
          rem_q <= '0;
          cnt_q <= CW'(NW);
          ci_q  <= '0;
          cj_q  <= '0;
          sx_q  <= '0;
          sy_q  <= '0;
          mass_q <= '0;
          if (thr_mode_q == tsc_pkg::MODE_BOX) begin
            num_q   <= NW'({box_sum_q, 8'h00});
            den_q   <= DW'(ss);
            state_q <= S_THR;
          end else if (thr_mode_q == tsc_pkg::MODE_SMART) begin
            num_q <= NW'({frame_sum_q, 8'h00});
            den_q <= DW'(frame_count_q);
            // empty background gives a zero mean
            state_q <= (frame_count_q != 12'd0) ? S_THR : S_CUTP;
          end else begin
            state_q <= S_SWEEP;
          end
        end
        S_THR: begin
          if (div_last) begin
            thr_q   <= TW'(num_nx);
            state_q <= (thr_mode_q == tsc_pkg::MODE_SMART) ? S_CUTP : S_SWEEP;
          end
        end
        S_CUTP: begin
          // raise the mean by a tenth of the gap up to the peak
          num_q <= NW'(peak40 - thr_q);
          state_q <= (peak40 > thr_q) ? S_CUT : S_SWEEP;
        end
        S_CUT: begin
          thr_q   <= thr_q + TW'(cut_prod >> tsc_pkg::CUT_SHIFT);
          state_q <= S_SWEEP;
        end
        S_SWEEP: begin
          if (last_i) begin
            ci_q <= '0;
            cj_q <= cj_q + IW'(1);
            if (last_j) begin
              state_q <= S_DRAIN;
            end
          end else begin
            ci_q <= ci_q + IW'(1);
          end
        end
        S_DRAIN: begin
          if (!v1_q && !v2_q) begin
            rem_q <= '0;
            cnt_q <= CW'(NW);
            num_q <= NW'({sx_q, 8'h00});
            den_q <= mass_q;
            ox_q  <= '0;
            oy_q  <= '0;
            state_q <= (mass_q != '0) ? S_OX : S_PUT;
          end
        end
        S_OX: begin
          if (div_last) begin
            ox_q  <= num_nx[OW-1:0];
            rem_q <= '0;
            cnt_q <= CW'(NW);
            num_q <= NW'({sy_q, 8'h00});
            state_q <= S_OY;
          end
        end
        S_OY: begin
          if (div_last) begin
            oy_q    <= num_nx[OW-1:0];
            state_q <= S_PUT;
          end
        end
        S_PUT: begin
          if (can_put) begin
            out_valid_q           <= 1'b1;
            out_q.centroid_col_q8 <= ocol[21] ? tsc_pkg::OUT_MAX : ocol[20:0];
            out_q.centroid_row_q8 <= orow[21] ? tsc_pkg::OUT_MAX : orow[20:0];
            out_q.no_mass         <= (mass_q == '0);
            frame_sum_q   <= '0;
            frame_count_q <= '0;
            box_sum_q     <= '0;
            box_peak_q    <= '0;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef SYNTHESIS
  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_IDLE))
    else $error("box store written while busy");

  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OX) |-> (!v1_q && !v2_q))
    else $error("offset division started before sweep drained");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_THR || state_q == S_OX || state_q == S_OY)
      |-> (rem_q < den_q))
    else $error("divider remainder not below divisor");

  a_no_mass_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) && out_q.no_mass |-> (out_q.centroid_col_q8 == {box_x_q, 8'h00}))
    else $error("empty box word not at box origin");
`endif

endmodule
